FILE: rtl/core/csas_pkg.sv
// Shared types and constants for the colour sensor ambient sequencer.
`timescale 1ns / 1ps
`default_nettype none

package csas_pkg;

    // Register widths and reset values
    localparam int unsigned CFG_W          = 16;
    localparam int unsigned CFG_INDEX_W    = 1;
    localparam int unsigned TICK_W         = 16;
    localparam int unsigned RESULT_W       = 16;
    localparam int unsigned COUNT_WIDTH_DEF = 16;

    localparam logic [CFG_W-1:0] WINDOW_TICKS_RESET = 16'd2400;
    localparam logic [CFG_W-1:0] SETTLE_TICKS_RESET = 16'd50;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_TICKS = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SETTLE_TICKS = 1'b1;

    // Input beat kinds carried on s_tuser
    localparam logic KIND_TICK  = 1'b0;
    localparam logic KIND_START = 1'b1;

    // Sequencer phases
    typedef enum logic [3:0] {
        PH_IDLE,
        PH_SETTLE_OFF,
        PH_AMB_R,
        PH_AMB_G,
        PH_AMB_B,
        PH_SETTLE_ON,
        PH_LIT_R,
        PH_LIT_G,
        PH_LIT_B
    } phase_t;

    // One result beat; last member sits in the lowest bits
    typedef struct packed {
        logic [RESULT_W-1:0] blue_count;
        logic [RESULT_W-1:0] green_count;
        logic [RESULT_W-1:0] red_count;
        logic                done_res;
        logic                busy_res;
        logic                led_on;
        logic                filter_s3;
        logic                filter_s2;
    } result_t;

    localparam int unsigned RESULT_BITS = $bits(result_t);
    localparam int unsigned M_TDATA_W   = ((RESULT_BITS + 7) / 8) * 8;
    localparam int unsigned S_TDATA_W   = 8;

endpackage

`default_nettype wire

FILE: rtl/core/csas_out_buf.sv
// Two-entry output buffer that decouples result beats from the input side.
`timescale 1ns / 1ps
`default_nettype none

module csas_out_buf #(
    parameter int unsigned DATA_W = csas_pkg::RESULT_BITS
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [DATA_W-1:0] in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [DATA_W-1:0]      out_data
);

    logic [1:0]        count_reg, count_next;
    logic [DATA_W-1:0] head_reg, head_next;
    logic [DATA_W-1:0] skid_reg, skid_next;
    logic              push, pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = head_reg;
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        count_next = count_reg;
        head_next  = head_reg;
        skid_next  = skid_reg;
        if (pop) begin
            if (count_reg == 2'd2) begin
                head_next = skid_reg;
            end else if (push) begin
                head_next = in_data;
            end
        end else if (push) begin
            if (count_reg == 2'd0) begin
                head_next = in_data;
            end else begin
                skid_next = in_data;
            end
        end
        count_next = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
        end
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

endmodule

`default_nettype wire

FILE: rtl/core/color_sensor_ambient_sequencer_top.sv
// Top level of the colour sensor ambient sequencer with ambient subtraction.
`timescale 1ns / 1ps
`default_nettype none

// Each input beat is either a start command (s_tuser = 1) or a one-microsecond
// tick carrying the sampled sensor level in s_tdata[0]. A start while idle
// switches the LED off, waits settle_ticks ticks, then runs red, green and
// blue counting windows of window_ticks ticks each, counting rising edges of
// the sensor level; the same is repeated with the LED lit. The first tick of
// every window only samples the level. The beat that closes the last lit
// window carries done_res = 1 and the new colour counts, each the lit count
// minus the ambient count, clamped at zero; counts hold until the next
// finished sequence. Starts while busy and ticks while idle change nothing.
// Every input beat gives exactly one result beat, showing the state after
// that beat. The block takes one beat per clock cycle: the sequencer state
// updates in the cycle the beat is accepted and the result is registered in
// a two-entry output buffer, so s_tready stays high while a single result
// waits and drops only when both buffer entries are full.
// Write window_ticks (index 0) and settle_ticks (index 1) only while idle.
module color_sensor_ambient_sequencer_top #(
    parameter int unsigned COUNT_WIDTH = csas_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    // Input channel
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    input  wire logic [csas_pkg::S_TDATA_W-1:0]       s_tdata,  // [0] sensor_level, rest zero
    input  wire logic                                 s_tuser,  // [0] kind (1 = start)
    // Result channel
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    // [0] filter_s2, [1] filter_s3, [2] led_on, [3] busy_res, [4] done_res,
    // [20:5] red_count, [36:21] green_count, [52:37] blue_count, rest zero
    output logic [csas_pkg::M_TDATA_W-1:0]            m_tdata,
    // Configuration write port
    input  wire logic                                 cfg_we,
    input  wire logic [csas_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [csas_pkg::CFG_W-1:0]           cfg_wdata
);

    localparam int unsigned CW = COUNT_WIDTH;
    localparam int unsigned DW = (CW > csas_pkg::RESULT_W) ? CW : csas_pkg::RESULT_W;
    localparam int unsigned TW = csas_pkg::TICK_W;

    // Configuration registers
    logic [csas_pkg::CFG_W-1:0] window_reg;
    logic [csas_pkg::CFG_W-1:0] settle_reg;

    // Sequencer state
    csas_pkg::phase_t phase_reg, phase_next;
    logic [TW-1:0]    tick_reg, tick_next;
    logic             prev_reg, prev_next;
    logic [CW-1:0]    edge_reg, edge_next;
    logic [CW-1:0]    amb_reg [3];
    logic [CW-1:0]    amb_next [3];
    logic [CW-1:0]    lit_reg [2];
    logic [CW-1:0]    lit_next [2];
    logic [csas_pkg::RESULT_W-1:0] res_reg [3];
    logic [csas_pkg::RESULT_W-1:0] res_next [3];

    logic             s_acc;
    logic             kind;
    logic             level;
    logic             done_w;
    logic [TW:0]      tick_inc;
    logic [TW:0]      win_len;
    logic             win_end;
    logic             settle_end;
    logic [CW-1:0]    edge_win;
    csas_pkg::result_t result_w;
    logic [csas_pkg::RESULT_BITS-1:0] buf_data;

    assign s_acc = s_tvalid && s_tready;
    assign kind  = s_tuser;
    assign level = s_tdata[0];

    // Lit minus ambient, clamped at zero and saturated to the result field
    function automatic logic [csas_pkg::RESULT_W-1:0] clamp_diff(
        input logic [CW-1:0] lit,
        input logic [CW-1:0] amb
    );
        logic [DW-1:0] d;
        d = (lit > amb) ? DW'(lit - amb) : '0;
        if (d > DW'({csas_pkg::RESULT_W{1'b1}})) begin
            clamp_diff = '1;
        end else begin
            clamp_diff = d[csas_pkg::RESULT_W-1:0];
        end
    endfunction

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= csas_pkg::WINDOW_TICKS_RESET;
            settle_reg <= csas_pkg::SETTLE_TICKS_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                csas_pkg::CFG_WINDOW_TICKS: window_reg <= cfg_wdata;
                csas_pkg::CFG_SETTLE_TICKS: settle_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Tick bookkeeping shared by settle waits and counting windows
    assign tick_inc   = {1'b0, tick_reg} + (TW+1)'(1);
    // A zero window behaves as a window of one tick
    assign win_len    = (window_reg == '0) ? (TW+1)'(1) : {1'b0, window_reg};
    assign win_end    = (tick_inc >= win_len);
    assign settle_end = (tick_inc >= {1'b0, settle_reg});

    // First tick of a window clears the count; later ticks count rising edges, saturating
    always_comb begin
        if (tick_reg == '0) begin
            edge_win = '0;
        end else if (level && !prev_reg && !(&edge_reg)) begin
            edge_win = edge_reg + CW'(1);
        end else begin
            edge_win = edge_reg;
        end
    end

    // Next state
    always_comb begin
        phase_next = phase_reg;
        tick_next  = tick_reg;
        prev_next  = prev_reg;
        edge_next  = edge_reg;
        amb_next   = amb_reg;
        lit_next   = lit_reg;
        res_next   = res_reg;
        done_w     = 1'b0;
        if (s_acc) begin
            if (kind == csas_pkg::KIND_START) begin
                // Start: honour only while idle; a zero settle goes straight to the window
                if (phase_reg == csas_pkg::PH_IDLE) begin
                    tick_next  = '0;
                    phase_next = (settle_reg == '0) ? csas_pkg::PH_AMB_R
                                                    : csas_pkg::PH_SETTLE_OFF;
                end
            end else begin
                unique case (phase_reg) inside
                    csas_pkg::PH_IDLE: ;
                    csas_pkg::PH_SETTLE_OFF, csas_pkg::PH_SETTLE_ON: begin
                        if (settle_end) begin
                            tick_next  = '0;
                            phase_next = (phase_reg == csas_pkg::PH_SETTLE_OFF)
                                         ? csas_pkg::PH_AMB_R : csas_pkg::PH_LIT_R;
                        end else begin
                            tick_next = tick_inc[TW-1:0];
                        end
                    end
                    default: begin
                        edge_next = edge_win;
                        prev_next = level;
                        if (!win_end) begin
                            tick_next = tick_inc[TW-1:0];
                        end else begin
                            tick_next = '0;
                            unique case (phase_reg)
                                csas_pkg::PH_AMB_R: begin
                                    amb_next[0] = edge_win;
                                    phase_next  = csas_pkg::PH_AMB_G;
                                end
                                csas_pkg::PH_AMB_G: begin
                                    amb_next[1] = edge_win;
                                    phase_next  = csas_pkg::PH_AMB_B;
                                end
                                csas_pkg::PH_AMB_B: begin
                                    amb_next[2] = edge_win;
                                    phase_next  = (settle_reg == '0) ? csas_pkg::PH_LIT_R
                                                                     : csas_pkg::PH_SETTLE_ON;
                                end
                                csas_pkg::PH_LIT_R: begin
                                    lit_next[0] = edge_win;
                                    phase_next  = csas_pkg::PH_LIT_G;
                                end
                                csas_pkg::PH_LIT_G: begin
                                    lit_next[1] = edge_win;
                                    phase_next  = csas_pkg::PH_LIT_B;
                                end
                                csas_pkg::PH_LIT_B: begin
                                    res_next[0] = clamp_diff(lit_reg[0], amb_reg[0]);
                                    res_next[1] = clamp_diff(lit_reg[1], amb_reg[1]);
                                    res_next[2] = clamp_diff(edge_win, amb_reg[2]);
                                    phase_next  = csas_pkg::PH_IDLE;
                                    done_w      = 1'b1;
                                end
                                default: ;
                            endcase
                        end
                    end
                endcase
            end
        end
    end

    // Result beat, built from the state after the accepted beat
    always_comb begin
        result_w             = '0;
        result_w.done_res    = done_w;
        result_w.busy_res    = (phase_next != csas_pkg::PH_IDLE);
        result_w.red_count   = res_next[0];
        result_w.green_count = res_next[1];
        result_w.blue_count  = res_next[2];
        unique case (phase_next) inside
            csas_pkg::PH_AMB_G, csas_pkg::PH_LIT_G: begin
                result_w.filter_s2 = 1'b1;
                result_w.filter_s3 = 1'b1;
            end
            csas_pkg::PH_AMB_B, csas_pkg::PH_LIT_B: begin
                result_w.filter_s3 = 1'b1;
            end
            default: ;
        endcase
        unique case (phase_next) inside
            csas_pkg::PH_SETTLE_ON, csas_pkg::PH_LIT_R,
            csas_pkg::PH_LIT_G, csas_pkg::PH_LIT_B: result_w.led_on = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= csas_pkg::PH_IDLE;
            tick_reg  <= '0;
            prev_reg  <= 1'b0;
            edge_reg  <= '0;
            amb_reg   <= '{default: '0};
            lit_reg   <= '{default: '0};
            res_reg   <= '{default: '0};
        end else begin
            phase_reg <= phase_next;
            tick_reg  <= tick_next;
            prev_reg  <= prev_next;
            edge_reg  <= edge_next;
            amb_reg   <= amb_next;
            lit_reg   <= lit_next;
            res_reg   <= res_next;
        end
    end

    // Hold result beats until the downstream side takes them
    csas_out_buf #(
        .DATA_W (csas_pkg::RESULT_BITS)
    ) u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_acc),
        .in_ready  (s_tready),
        .in_data   (result_w),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (buf_data)
    );

    assign m_tdata = csas_pkg::M_TDATA_W'(buf_data);

`ifndef SYNTHESIS
    // A start while idle always launches a sequence
    a_start_launches: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && kind == csas_pkg::KIND_START && phase_reg == csas_pkg::PH_IDLE)
        |=> (phase_reg != csas_pkg::PH_IDLE))
        else $error("start beat in idle did not launch a sequence");

    // Reported counts move only on the finishing beat
    a_counts_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_acc && done_w) |=> ($stable(res_reg[0]) && $stable(res_reg[1])
                                && $stable(res_reg[2])))
        else $error("colour counts changed without a finished sequence");

    // A tick in idle leaves the sequencer untouched
    a_idle_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && kind == csas_pkg::KIND_TICK && phase_reg == csas_pkg::PH_IDLE)
        |=> (phase_reg == csas_pkg::PH_IDLE && $stable(edge_reg) && $stable(tick_reg)))
        else $error("tick in idle changed the sequencer state");

    // Input stalls only while a result is on offer
    a_stall_has_result: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no result pending");
`endif

endmodule

`default_nettype wire

FILE: test/tb.sv
// Self-checking testbench for the colour sensor ambient sequencer top level.
`timescale 1ns / 1ps

module tb;

    localparam int unsigned EDGE_W    = csas_pkg::COUNT_WIDTH_DEF;
    localparam int unsigned RUN_LIMIT = 3_000_000;
    localparam int          TBL_ROWS  = 21;
    // Rows before this one run at the reset register values
    localparam int          CFG_SPLIT = 1;

    // Readouts that can be typed in directly
    localparam csas_pkg::result_t RES_IDLE = '0;
    localparam csas_pkg::result_t RES_BUSY = '{busy_res: 1'b1, default: '0};
    localparam csas_pkg::result_t RES_DONE = '{done_res: 1'b1, blue_count: 16'd1,
                                               default: '0};

    typedef struct packed {
        logic              kind;
        logic              level;
        logic              typed;
        csas_pkg::result_t want;
    } beat_row_t;

    logic                             aclk      = 1'b0;
    logic                             aresetn   = 1'b0;
    logic                             s_tvalid  = 1'b0;
    logic                             s_tready;
    logic [csas_pkg::S_TDATA_W-1:0]   s_tdata   = '0;  // [0] sensor_level, rest zero
    logic                             s_tuser   = 1'b0; // [0] kind (1 = start)
    logic                             m_tvalid;
    logic                             m_tready  = 1'b0;
    // [0] filter_s2, [1] filter_s3, [2] led_on, [3] busy_res, [4] done_res,
    // [20:5] red_count, [36:21] green_count, [52:37] blue_count, rest zero
    logic [csas_pkg::M_TDATA_W-1:0]   m_tdata;
    logic                             cfg_we    = 1'b0;
    logic [csas_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [csas_pkg::CFG_W-1:0]       cfg_wdata = '0;

    // Mirror of the sequencer, kept in step with every accepted input beat
    csas_pkg::phase_t                 seq_phase  = csas_pkg::PH_IDLE;
    int unsigned                      tick_cnt   = 0;
    logic                             last_level = 1'b0;
    logic [EDGE_W-1:0]                edge_cnt   = '0;
    logic [EDGE_W-1:0]                amb_edges [3] = '{default: '0};
    logic [EDGE_W-1:0]                lit_edges [2] = '{default: '0};
    logic [csas_pkg::RESULT_W-1:0]    colour_out [3] = '{default: '0};
    logic [csas_pkg::CFG_W-1:0]       win_len    = csas_pkg::WINDOW_TICKS_RESET;
    logic [csas_pkg::CFG_W-1:0]       settle_len = csas_pkg::SETTLE_TICKS_RESET;

    // Readouts still owed by the block, oldest first
    csas_pkg::result_t                awaited [$];

    int unsigned                      mismatches    = 0;
    int unsigned                      readouts_seen = 0;
    int unsigned                      beats_sent    = 0;
    int unsigned                      cycles        = 0;

    // Sender and receiver idling controls
    bit                               tx_steady   = 1'b0;
    bit                               rx_free     = 1'b0;
    int unsigned                      burst_left  = 0;
    int unsigned                      rx_left     = 0;
    bit                               rx_open     = 1'b0;
    int unsigned                      level_bias  = 50;

    beat_row_t                        beat_tbl [TBL_ROWS];

    color_sensor_ambient_sequencer_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Lit edges minus ambient edges, floored at zero and capped at the field width
    function automatic logic [csas_pkg::RESULT_W-1:0] lit_minus_ambient(
        input logic [EDGE_W-1:0] lit,
        input logic [EDGE_W-1:0] amb
    );
        logic [EDGE_W-1:0] diff;
        diff = (lit > amb) ? lit - amb : '0;
        return (64'(diff) > 64'hFFFF) ? '1 : csas_pkg::RESULT_W'(diff);
    endfunction

    // Advance the mirrored sequencer by one input beat and return the readout
    function automatic csas_pkg::result_t next_readout(input logic kind, input logic level);
        csas_pkg::result_t r;
        logic              finished;
        int unsigned       win;
        r        = '0;
        finished = 1'b0;
        if (kind == csas_pkg::KIND_START) begin
            // Drop a start while a sequence runs
            if (seq_phase == csas_pkg::PH_IDLE) begin
                tick_cnt  = 0;
                seq_phase = (settle_len == 0) ? csas_pkg::PH_AMB_R : csas_pkg::PH_SETTLE_OFF;
            end
        end else if (seq_phase == csas_pkg::PH_SETTLE_OFF ||
                     seq_phase == csas_pkg::PH_SETTLE_ON) begin
            tick_cnt++;
            if (tick_cnt >= settle_len) begin
                seq_phase = (seq_phase == csas_pkg::PH_SETTLE_OFF) ? csas_pkg::PH_AMB_R
                                                                   : csas_pkg::PH_LIT_R;
                tick_cnt  = 0;
            end
        end else if (seq_phase != csas_pkg::PH_IDLE) begin
            // First tick of a window only samples the level
            if (tick_cnt == 0)
                edge_cnt = '0;
            else if (level && !last_level && edge_cnt != '1)
                edge_cnt++;
            last_level = level;
            tick_cnt++;
            win = (win_len == 0) ? 1 : win_len;
            if (tick_cnt >= win) begin
                tick_cnt = 0;
                case (seq_phase)
                    csas_pkg::PH_AMB_R: begin
                        amb_edges[0] = edge_cnt;
                        seq_phase    = csas_pkg::PH_AMB_G;
                    end
                    csas_pkg::PH_AMB_G: begin
                        amb_edges[1] = edge_cnt;
                        seq_phase    = csas_pkg::PH_AMB_B;
                    end
                    csas_pkg::PH_AMB_B: begin
                        amb_edges[2] = edge_cnt;
                        seq_phase    = (settle_len == 0) ? csas_pkg::PH_LIT_R
                                                         : csas_pkg::PH_SETTLE_ON;
                    end
                    csas_pkg::PH_LIT_R: begin
                        lit_edges[0] = edge_cnt;
                        seq_phase    = csas_pkg::PH_LIT_G;
                    end
                    csas_pkg::PH_LIT_G: begin
                        lit_edges[1] = edge_cnt;
                        seq_phase    = csas_pkg::PH_LIT_B;
                    end
                    default: begin
                        colour_out[0] = lit_minus_ambient(lit_edges[0], amb_edges[0]);
                        colour_out[1] = lit_minus_ambient(lit_edges[1], amb_edges[1]);
                        colour_out[2] = lit_minus_ambient(edge_cnt, amb_edges[2]);
                        seq_phase     = csas_pkg::PH_IDLE;
                        finished      = 1'b1;
                    end
                endcase
            end
        end

        case (seq_phase)
            csas_pkg::PH_AMB_G, csas_pkg::PH_LIT_G: begin
                r.filter_s2 = 1'b1;
                r.filter_s3 = 1'b1;
            end
            csas_pkg::PH_AMB_B, csas_pkg::PH_LIT_B: begin
                r.filter_s3 = 1'b1;
            end
            default: ;
        endcase
        r.led_on      = (seq_phase == csas_pkg::PH_SETTLE_ON) ||
                        (seq_phase == csas_pkg::PH_LIT_R) ||
                        (seq_phase == csas_pkg::PH_LIT_G) ||
                        (seq_phase == csas_pkg::PH_LIT_B);
        r.busy_res    = (seq_phase != csas_pkg::PH_IDLE);
        r.done_res    = finished;
        r.red_count   = colour_out[0];
        r.green_count = colour_out[1];
        r.blue_count  = colour_out[2];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        $display("[%0t] readout %0d: %s is %0h, expected %0h",
                 $realtime, readouts_seen, what, got, want);
    endtask

    // Drive one input beat from a falling edge, hold until it is taken, then
    // queue its readout. Returns at a falling edge with no assignment made.
    task automatic send_beat(input logic kind, input logic level, input bit typed,
                             input csas_pkg::result_t want);
        csas_pkg::result_t r;
        if (!tx_steady && burst_left == 0) begin
            // Idle for a while between bursts
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
            burst_left = $urandom_range(1, 24);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {{(csas_pkg::S_TDATA_W-1){1'b0}}, level};
        do @(posedge aclk); while (!s_tready);
        r = next_readout(kind, level);
        awaited.push_back(typed ? want : r);
        beats_sent++;
        if (burst_left != 0)
            burst_left--;
        @(negedge aclk);
    endtask

    // Hold the sender off until every owed readout has arrived
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (awaited.size() != 0);
    endtask

    // Write both registers while the sequencer is idle
    task automatic load_config(input logic [csas_pkg::CFG_W-1:0] win,
                               input logic [csas_pkg::CFG_W-1:0] settle);
        drain_results();
        repeat (4) @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= csas_pkg::CFG_WINDOW_TICKS;
        cfg_wdata <= win;
        @(negedge aclk);
        cfg_index <= csas_pkg::CFG_SETTLE_TICKS;
        cfg_wdata <= settle;
        @(negedge aclk);
        cfg_we     <= 1'b0;
        win_len    = win;
        settle_len = settle;
        @(negedge aclk);
    endtask

    // Run ticks until the sequencer is idle again, optionally opening with a
    // start and sprinkling stray starts that must be ignored
    task automatic run_sequence(input bit with_start, input bit noisy);
        csas_pkg::phase_t seen_phase;
        logic             lvl;
        seen_phase = csas_pkg::PH_IDLE;
        if (with_start)
            send_beat(csas_pkg::KIND_START, 1'($urandom_range(0, 1)), 1'b0, '0);
        while (seq_phase != csas_pkg::PH_IDLE) begin
            // Pick a fresh edge density for every window so lit and ambient differ
            if (seq_phase != seen_phase) begin
                seen_phase = seq_phase;
                level_bias = $urandom_range(5, 95);
            end
            lvl = ($urandom_range(0, 99) < level_bias);
            if (noisy && $urandom_range(0, 11) == 0)
                send_beat(csas_pkg::KIND_START, lvl, 1'b0, '0);
            else
                send_beat(csas_pkg::KIND_TICK, lvl, 1'b0, '0);
        end
    endtask

    // Receiver: alternate ready and stalled runs of random length
    always @(negedge aclk) begin
        if (rx_free) begin
            m_tready <= 1'b1;
        end else begin
            if (rx_left == 0) begin
                rx_open = !rx_open;
                rx_left = rx_open ? $urandom_range(1, 12) : $urandom_range(1, 5);
            end
            rx_left--;
            m_tready <= rx_open;
        end
    end

    // Compare every result beat with the oldest owed readout
    always @(posedge aclk) begin : check_readout
        csas_pkg::result_t got;
        csas_pkg::result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = csas_pkg::result_t'(m_tdata[csas_pkg::RESULT_BITS-1:0]);
            readouts_seen++;
            if (awaited.size() == 0) begin
                report_mismatch("beat with nothing owed, low tdata", m_tdata[31:0], '0);
            end else begin
                want = awaited.pop_front();
                if (got.filter_s2 !== want.filter_s2)
                    report_mismatch("filter_s2", 32'(got.filter_s2), 32'(want.filter_s2));
                if (got.filter_s3 !== want.filter_s3)
                    report_mismatch("filter_s3", 32'(got.filter_s3), 32'(want.filter_s3));
                if (got.led_on !== want.led_on)
                    report_mismatch("led_on", 32'(got.led_on), 32'(want.led_on));
                if (got.busy_res !== want.busy_res)
                    report_mismatch("busy_res", 32'(got.busy_res), 32'(want.busy_res));
                if (got.done_res !== want.done_res)
                    report_mismatch("done_res", 32'(got.done_res), 32'(want.done_res));
                if (got.red_count !== want.red_count)
                    report_mismatch("red_count", 32'(got.red_count), 32'(want.red_count));
                if (got.green_count !== want.green_count)
                    report_mismatch("green_count", 32'(got.green_count),
                                    32'(want.green_count));
                if (got.blue_count !== want.blue_count)
                    report_mismatch("blue_count", 32'(got.blue_count),
                                    32'(want.blue_count));
                if (m_tdata[csas_pkg::M_TDATA_W-1:csas_pkg::RESULT_BITS] !== '0)
                    report_mismatch("tdata padding",
                                    32'(m_tdata[csas_pkg::M_TDATA_W-1:csas_pkg::RESULT_BITS]),
                                    '0);
            end
        end
    end

    // Guard against a hung handshake
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == RUN_LIMIT) begin
            $display("cycle limit reached with %0d readouts outstanding", awaited.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        int          p;
        int unsigned phase_base;

        // Reset register values: a tick while idle changes nothing
        beat_tbl[0]  = '{csas_pkg::KIND_TICK,  1'b1, 1'b1, RES_IDLE};
        // Window of three ticks, no settle: start lands straight in the red window
        beat_tbl[1]  = '{csas_pkg::KIND_START, 1'b0, 1'b1, RES_BUSY};
        // Ambient red: one edge
        beat_tbl[2]  = '{csas_pkg::KIND_TICK,  1'b1, 1'b0, RES_IDLE};
        beat_tbl[3]  = '{csas_pkg::KIND_TICK,  1'b0, 1'b0, RES_IDLE};
        beat_tbl[4]  = '{csas_pkg::KIND_TICK,  1'b1, 1'b0, RES_IDLE};
        // Ambient green: one edge, with a stray start that must not count as a tick
        beat_tbl[5]  = '{csas_pkg::KIND_TICK,  1'b0, 1'b0, RES_IDLE};
        beat_tbl[6]  = '{csas_pkg::KIND_START, 1'b1, 1'b0, RES_IDLE};
        beat_tbl[7]  = '{csas_pkg::KIND_TICK,  1'b1, 1'b0, RES_IDLE};
        beat_tbl[8]  = '{csas_pkg::KIND_TICK,  1'b1, 1'b0, RES_IDLE};
        // Ambient blue: level stuck high, no edges
        beat_tbl[9]  = '{csas_pkg::KIND_TICK,  1'b1, 1'b0, RES_IDLE};
        beat_tbl[10] = '{csas_pkg::KIND_TICK,  1'b1, 1'b0, RES_IDLE};
        beat_tbl[11] = '{csas_pkg::KIND_TICK,  1'b1, 1'b0, RES_IDLE};
        // Lit red: no edges, so the result clamps at zero
        beat_tbl[12] = '{csas_pkg::KIND_TICK,  1'b1, 1'b0, RES_IDLE};
        beat_tbl[13] = '{csas_pkg::KIND_TICK,  1'b1, 1'b0, RES_IDLE};
        beat_tbl[14] = '{csas_pkg::KIND_TICK,  1'b1, 1'b0, RES_IDLE};
        // Lit green: one edge, equal to ambient
        beat_tbl[15] = '{csas_pkg::KIND_TICK,  1'b0, 1'b0, RES_IDLE};
        beat_tbl[16] = '{csas_pkg::KIND_TICK,  1'b1, 1'b0, RES_IDLE};
        beat_tbl[17] = '{csas_pkg::KIND_TICK,  1'b0, 1'b0, RES_IDLE};
        // Lit blue: high on the opening tick after a low must not count
        beat_tbl[18] = '{csas_pkg::KIND_TICK,  1'b1, 1'b0, RES_IDLE};
        beat_tbl[19] = '{csas_pkg::KIND_TICK,  1'b0, 1'b0, RES_IDLE};
        beat_tbl[20] = '{csas_pkg::KIND_TICK,  1'b1, 1'b1, RES_DONE};

        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part
        for (int i = 0; i < TBL_ROWS; i++) begin
            if (i == CFG_SPLIT) begin
                // Shrink the windows and drop the settle wait
                load_config(16'd3, 16'd0);
            end
            send_beat(beat_tbl[i].kind, beat_tbl[i].level, beat_tbl[i].typed,
                      beat_tbl[i].want);
        end

        // Random part: whole sequences with noise, over several register settings
        for (p = 0; p < 6; p++) begin
            tx_steady = (p == 2);
            rx_free   = (p == 3);
            case (p)
                0:       load_config(16'd0, 16'd1);   // zero window acts as one tick
                1:       load_config(16'd1, 16'd0);
                default: load_config(16'($urandom_range(2, 7)),
                                     16'($urandom_range(0, 4)));
            endcase
            phase_base = beats_sent;
            while (beats_sent - phase_base < 110) begin
                // Ticks while idle should change nothing
                if ($urandom_range(0, 3) == 0)
                    repeat ($urandom_range(1, 3))
                        send_beat(csas_pkg::KIND_TICK, 1'($urandom_range(0, 1)), 1'b0, '0);
                if ($urandom_range(0, 9) == 0)
                    drain_results();
                run_sequence(1'b1, 1'b1);
            end
        end

        drain_results();
        repeat (8) @(posedge aclk);
        if (mismatches == 0 && awaited.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
